// ===== rtl/core/wpdh_pkg.sv =====
// Shared types and constants for the weighted pair distance histogram.
// No dependencies; used by wpdh_ctrl, wpdh_datapath and the top level.
package wpdh_pkg;

   localparam int COORD_W = 18;
   localparam int WEIGHT_W = 16;
   localparam int POINT_W = 3 * COORD_W + WEIGHT_W;
   localparam int REQ_DATA_W = 72;
   localparam int CMD_W = 2;
   localparam int BIN_IDX_W = 6;
   localparam int BIN_VAL_W = 48;
   localparam int BWIDTH_W = 12;
   localparam int DIFF_W = COORD_W + 1;
   localparam int SQ_W = 2 * COORD_W + 1;
   localparam int D2_W = SQ_W + 2;
   localparam int DIST_W = 20;
   localparam int PROD_W = 2 * WEIGHT_W;
   localparam int DIV_CNT_W = 5;
   localparam int CSR_IDX_W = 1;

   localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
   localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_BIN_WIDTH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SELF_MODE = 1'd1;

   localparam logic [BWIDTH_W-1:0] BIN_WIDTH_RESET = 12'd16;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_PAIR_INIT,
      ST_FETCH,
      ST_DIFF,
      ST_SQUARE,
      ST_SUM,
      ST_SQRT_LOAD,
      ST_SQRT,
      ST_DIV_LOAD,
      ST_DIV,
      ST_ACC_RD,
      ST_ACC_WR,
      ST_SELF_INIT,
      ST_SELF_FETCH,
      ST_SELF_MUL,
      ST_SELF_RD,
      ST_SELF_WR,
      ST_OUT_INIT,
      ST_OUT_RD,
      ST_OUT_LOAD,
      ST_OUT_WAIT
   } state_type;

   typedef struct packed {
      logic load_a;
      logic load_b;
      logic clr_init;
      logic clr_step;
      logic pair_init;
      logic fetch;
      logic diff;
      logic square;
      logic sum;
      logic sqrt_init;
      logic sqrt_step;
      logic div_init;
      logic div_step;
      logic acc_rd;
      logic acc_wr;
      logic pair_next;
      logic self_init;
      logic self_mul;
      logic self_next;
      logic out_init;
      logic out_rd;
      logic out_load;
      logic out_next;
   } dp_cmd_type;

   typedef struct packed {
      logic self_mode;
      logic clr_last;
      logic pairs_none;
      logic pair_last;
      logic sqrt_done;
      logic div_done;
      logic self_none;
      logic self_last;
      logic out_last;
      logic rsp_taken;
   } dp_status_type;

endpackage

// ===== rtl/core/wpdh_ctrl.sv =====
// Sequencer for the histogram block: load, clear, pair walk, self terms, readout.
// Depends on wpdh_pkg; drives wpdh_datapath through dp_cmd_type.
module wpdh_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [wpdh_pkg::CMD_W-1:0]   req_command,
   input  wpdh_pkg::dp_status_type      status,
   output wpdh_pkg::dp_cmd_type         cmd
);

   wpdh_pkg::state_type state_ff;
   wpdh_pkg::state_type state_in;
   logic req_xfer;

   assign req_xfer = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wpdh_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wpdh_pkg::ST_IDLE: begin
            if (req_xfer && req_command == wpdh_pkg::CMD_COMPUTE) begin
               state_in = wpdh_pkg::ST_CLEAR;
            end
         end
         wpdh_pkg::ST_CLEAR: begin
            if (status.clr_last) begin
               state_in = wpdh_pkg::ST_PAIR_INIT;
            end
         end
         wpdh_pkg::ST_PAIR_INIT: begin
            if (!status.pairs_none) begin
               state_in = wpdh_pkg::ST_FETCH;
            end else if (status.self_mode) begin
               state_in = wpdh_pkg::ST_SELF_INIT;
            end else begin
               state_in = wpdh_pkg::ST_OUT_INIT;
            end
         end
         wpdh_pkg::ST_FETCH:     state_in = wpdh_pkg::ST_DIFF;
         wpdh_pkg::ST_DIFF:      state_in = wpdh_pkg::ST_SQUARE;
         wpdh_pkg::ST_SQUARE:    state_in = wpdh_pkg::ST_SUM;
         wpdh_pkg::ST_SUM:       state_in = wpdh_pkg::ST_SQRT_LOAD;
         wpdh_pkg::ST_SQRT_LOAD: state_in = wpdh_pkg::ST_SQRT;
         wpdh_pkg::ST_SQRT: begin
            if (status.sqrt_done) begin
               state_in = wpdh_pkg::ST_DIV_LOAD;
            end
         end
         wpdh_pkg::ST_DIV_LOAD:  state_in = wpdh_pkg::ST_DIV;
         wpdh_pkg::ST_DIV: begin
            if (status.div_done) begin
               state_in = wpdh_pkg::ST_ACC_RD;
            end
         end
         wpdh_pkg::ST_ACC_RD:    state_in = wpdh_pkg::ST_ACC_WR;
         wpdh_pkg::ST_ACC_WR: begin
            if (!status.pair_last) begin
               state_in = wpdh_pkg::ST_FETCH;
            end else if (status.self_mode) begin
               state_in = wpdh_pkg::ST_SELF_INIT;
            end else begin
               state_in = wpdh_pkg::ST_OUT_INIT;
            end
         end
         wpdh_pkg::ST_SELF_INIT: begin
            if (status.self_none) begin
               state_in = wpdh_pkg::ST_OUT_INIT;
            end else begin
               state_in = wpdh_pkg::ST_SELF_FETCH;
            end
         end
         wpdh_pkg::ST_SELF_FETCH: state_in = wpdh_pkg::ST_SELF_MUL;
         wpdh_pkg::ST_SELF_MUL:   state_in = wpdh_pkg::ST_SELF_RD;
         wpdh_pkg::ST_SELF_RD:    state_in = wpdh_pkg::ST_SELF_WR;
         wpdh_pkg::ST_SELF_WR: begin
            if (status.self_last) begin
               state_in = wpdh_pkg::ST_OUT_INIT;
            end else begin
               state_in = wpdh_pkg::ST_SELF_FETCH;
            end
         end
         wpdh_pkg::ST_OUT_INIT:  state_in = wpdh_pkg::ST_OUT_RD;
         wpdh_pkg::ST_OUT_RD:    state_in = wpdh_pkg::ST_OUT_LOAD;
         wpdh_pkg::ST_OUT_LOAD:  state_in = wpdh_pkg::ST_OUT_WAIT;
         wpdh_pkg::ST_OUT_WAIT: begin
            if (status.rsp_taken) begin
               if (status.out_last) begin
                  state_in = wpdh_pkg::ST_IDLE;
               end else begin
                  state_in = wpdh_pkg::ST_OUT_RD;
               end
            end
         end
         default: state_in = wpdh_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      case (state_ff)
         wpdh_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load_a = req_xfer && req_command == wpdh_pkg::CMD_LOAD_A;
            cmd.load_b = req_xfer && req_command == wpdh_pkg::CMD_LOAD_B;
            cmd.clr_init = req_xfer && req_command == wpdh_pkg::CMD_COMPUTE;
         end
         wpdh_pkg::ST_CLEAR:      cmd.clr_step = 1'b1;
         wpdh_pkg::ST_PAIR_INIT:  cmd.pair_init = 1'b1;
         wpdh_pkg::ST_FETCH:      cmd.fetch = 1'b1;
         wpdh_pkg::ST_DIFF:       cmd.diff = 1'b1;
         wpdh_pkg::ST_SQUARE:     cmd.square = 1'b1;
         wpdh_pkg::ST_SUM:        cmd.sum = 1'b1;
         wpdh_pkg::ST_SQRT_LOAD:  cmd.sqrt_init = 1'b1;
         wpdh_pkg::ST_SQRT:       cmd.sqrt_step = !status.sqrt_done;
         wpdh_pkg::ST_DIV_LOAD:   cmd.div_init = 1'b1;
         wpdh_pkg::ST_DIV:        cmd.div_step = !status.div_done;
         wpdh_pkg::ST_ACC_RD:     cmd.acc_rd = 1'b1;
         wpdh_pkg::ST_ACC_WR: begin
            cmd.acc_wr = 1'b1;
            cmd.pair_next = !status.pair_last;
         end
         wpdh_pkg::ST_SELF_INIT:  cmd.self_init = 1'b1;
         wpdh_pkg::ST_SELF_FETCH: cmd.fetch = 1'b1;
         wpdh_pkg::ST_SELF_MUL:   cmd.self_mul = 1'b1;
         wpdh_pkg::ST_SELF_RD:    cmd.acc_rd = 1'b1;
         wpdh_pkg::ST_SELF_WR: begin
            cmd.acc_wr = 1'b1;
            cmd.self_next = !status.self_last;
         end
         wpdh_pkg::ST_OUT_INIT:   cmd.out_init = 1'b1;
         wpdh_pkg::ST_OUT_RD:     cmd.out_rd = 1'b1;
         wpdh_pkg::ST_OUT_LOAD:   cmd.out_load = 1'b1;
         wpdh_pkg::ST_OUT_WAIT:   cmd.out_next = status.rsp_taken && !status.out_last;
         default: begin
            cmd = '0;
         end
      endcase
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !status.rsp_taken)
      else $error("input taken while a bin transfer completes");
   a_sqrt_then_div: assert property (@(posedge clock) disable iff (reset)
      cmd.div_init |-> $past(status.sqrt_done))
      else $error("division started before square root finished");
   a_acc_after_rd: assert property (@(posedge clock) disable iff (reset)
      cmd.acc_wr |-> $past(cmd.acc_rd))
      else $error("bin write without preceding read");

endmodule

// ===== rtl/core/wpdh_datapath.sv =====
// Point memories, distance unit (squares, bit-serial isqrt, restoring divide),
// histogram memory and result register. Depends on wpdh_pkg; run by wpdh_ctrl.
module wpdh_datapath #(
   parameter int MAX_POINTS = 1024,
   parameter int NUM_BINS = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  wpdh_pkg::dp_cmd_type              cmd,
   output wpdh_pkg::dp_status_type           status,
   input  logic [wpdh_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              csr_write,
   input  logic [wpdh_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [wpdh_pkg::BWIDTH_W-1:0]     csr_data,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [wpdh_pkg::BIN_VAL_W-1:0]    rsp_tdata,
   output logic [wpdh_pkg::BIN_IDX_W-1:0]    rsp_tuser,
   output logic                              rsp_tlast
);

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int KW = $clog2(NUM_BINS);
   localparam int PW = wpdh_pkg::POINT_W;
   localparam int CRD = wpdh_pkg::COORD_W;
   localparam int WW = wpdh_pkg::WEIGHT_W;
   localparam int VW = wpdh_pkg::BIN_VAL_W;
   localparam int DV = wpdh_pkg::DIST_W;
   localparam int BW = wpdh_pkg::BWIDTH_W;
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_POINTS);
   localparam logic [KW-1:0] LAST_BIN = KW'(NUM_BINS - 1);
   localparam logic [wpdh_pkg::D2_W-1:0] SQRT_BIT0 =
      {1'b1, {(wpdh_pkg::D2_W - 1){1'b0}}};

   // config
   logic [BW-1:0] bin_width_ff;
   logic          self_mode_ff;
   logic [BW-1:0] width_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_width_ff <= wpdh_pkg::BIN_WIDTH_RESET;
         self_mode_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            wpdh_pkg::REG_BIN_WIDTH: bin_width_ff <= csr_data;
            wpdh_pkg::REG_SELF_MODE: self_mode_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign width_eff = (bin_width_ff == '0) ? BW'(1) : bin_width_ff;

   // point stores and counts
   logic [PW-1:0] mem_a [MAX_POINTS];
   logic [PW-1:0] mem_b [MAX_POINTS];
   logic [CW-1:0] count_a_ff, count_a_in;
   logic [CW-1:0] count_b_ff, count_b_in;
   logic [AW-1:0] i_ff, i_in, j_ff, j_in;
   logic          self_phase_ff, self_phase_in;
   logic [PW-1:0] pa_ff, pa2_ff, pb_ff;
   logic [AW-1:0] addr_a2;

   assign addr_a2 = self_phase_ff ? i_ff : j_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_a && count_a_ff < MAX_CNT) begin
         mem_a[count_a_ff[AW-1:0]] <= req_tdata[PW-1:0];
      end
      if (cmd.load_b && count_b_ff < MAX_CNT) begin
         mem_b[count_b_ff[AW-1:0]] <= req_tdata[PW-1:0];
      end
      if (cmd.fetch) begin
         pa_ff <= mem_a[i_ff];
         pa2_ff <= mem_a[addr_a2];
         pb_ff <= mem_b[j_ff];
      end
   end

   logic [CW-1:0] i_ext, j_ext, cnt_a_m1, cnt_a_m2, cnt_b_m1;

   assign i_ext = CW'(i_ff);
   assign j_ext = CW'(j_ff);
   assign cnt_a_m1 = count_a_ff - CW'(1);
   assign cnt_a_m2 = count_a_ff - CW'(2);
   assign cnt_b_m1 = count_b_ff - CW'(1);

   always_comb begin
      count_a_in = count_a_ff;
      count_b_in = count_b_ff;
      i_in = i_ff;
      j_in = j_ff;
      self_phase_in = self_phase_ff;
      if (cmd.load_a && count_a_ff < MAX_CNT) begin
         count_a_in = count_a_ff + CW'(1);
      end
      if (cmd.load_b && count_b_ff < MAX_CNT) begin
         count_b_in = count_b_ff + CW'(1);
      end
      if (cmd.out_init) begin
         count_a_in = '0;
         count_b_in = '0;
      end
      if (cmd.pair_init) begin
         i_in = '0;
         j_in = self_mode_ff ? AW'(1) : '0;
         self_phase_in = 1'b0;
      end
      if (cmd.pair_next) begin
         if (self_mode_ff) begin
            if (j_ext == cnt_a_m1) begin
               i_in = i_ff + AW'(1);
               j_in = i_ff + AW'(2);
            end else begin
               j_in = j_ff + AW'(1);
            end
         end else begin
            if (j_ext == cnt_b_m1) begin
               i_in = i_ff + AW'(1);
               j_in = '0;
            end else begin
               j_in = j_ff + AW'(1);
            end
         end
      end
      if (cmd.self_init) begin
         i_in = '0;
         self_phase_in = 1'b1;
      end
      if (cmd.self_next) begin
         i_in = i_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_a_ff <= '0;
         count_b_ff <= '0;
         i_ff <= '0;
         j_ff <= '0;
         self_phase_ff <= 1'b0;
      end else begin
         count_a_ff <= count_a_in;
         count_b_ff <= count_b_in;
         i_ff <= i_in;
         j_ff <= j_in;
         self_phase_ff <= self_phase_in;
      end
   end

   // distance unit
   logic [PW-1:0] pother;
   logic signed [wpdh_pkg::DIFF_W-1:0] dx_ff, dy_ff, dz_ff;
   logic [wpdh_pkg::PROD_W-1:0] prod_ff;
   logic [wpdh_pkg::SQ_W-1:0] sqx_ff, sqy_ff, sqz_ff;
   logic [wpdh_pkg::D2_W-1:0] d2_ff;
   logic [wpdh_pkg::D2_W-1:0] sx_ff, sres_ff, sbit_ff;
   logic [wpdh_pkg::D2_W-1:0] strial;
   logic [DV-1:0] quot_ff;
   logic [BW-1:0] rem_ff;
   logic [BW:0] dtrial;
   logic [wpdh_pkg::DIV_CNT_W-1:0] dcnt_ff;
   logic signed [2*wpdh_pkg::DIFF_W-1:0] mx, my, mz;

   assign pother = self_mode_ff ? pa2_ff : pb_ff;
   assign mx = dx_ff * dx_ff;
   assign my = dy_ff * dy_ff;
   assign mz = dz_ff * dz_ff;
   assign strial = sres_ff + sbit_ff;
   assign dtrial = {rem_ff, quot_ff[DV-1]};

   always_ff @(posedge clock) begin
      if (cmd.diff) begin
         dx_ff <= $signed({pa_ff[CRD-1], pa_ff[CRD-1:0]})
            - $signed({pother[CRD-1], pother[CRD-1:0]});
         dy_ff <= $signed({pa_ff[2*CRD-1], pa_ff[2*CRD-1:CRD]})
            - $signed({pother[2*CRD-1], pother[2*CRD-1:CRD]});
         dz_ff <= $signed({pa_ff[3*CRD-1], pa_ff[3*CRD-1:2*CRD]})
            - $signed({pother[3*CRD-1], pother[3*CRD-1:2*CRD]});
         prod_ff <= pa_ff[PW-1:3*CRD] * pother[PW-1:3*CRD];
      end
      if (cmd.self_mul) begin
         prod_ff <= pa_ff[PW-1:3*CRD] * pa2_ff[PW-1:3*CRD];
      end
      if (cmd.square) begin
         sqx_ff <= mx[wpdh_pkg::SQ_W-1:0];
         sqy_ff <= my[wpdh_pkg::SQ_W-1:0];
         sqz_ff <= mz[wpdh_pkg::SQ_W-1:0];
      end
      if (cmd.sum) begin
         d2_ff <= wpdh_pkg::D2_W'(sqx_ff) + wpdh_pkg::D2_W'(sqy_ff)
            + wpdh_pkg::D2_W'(sqz_ff);
      end
      if (cmd.div_init) begin
         quot_ff <= sres_ff[DV-1:0];
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         if (dtrial >= {1'b0, width_eff}) begin
            rem_ff <= BW'(dtrial - {1'b0, width_eff});
            quot_ff <= {quot_ff[DV-2:0], 1'b1};
         end else begin
            rem_ff <= dtrial[BW-1:0];
            quot_ff <= {quot_ff[DV-2:0], 1'b0};
         end
      end
   end

   // one result bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         sbit_ff <= '0;
         dcnt_ff <= '0;
      end else begin
         if (cmd.sqrt_init) begin
            sbit_ff <= SQRT_BIT0;
         end else if (cmd.sqrt_step) begin
            sbit_ff <= sbit_ff >> 2;
         end
         if (cmd.div_init) begin
            dcnt_ff <= wpdh_pkg::DIV_CNT_W'(DV);
         end else if (cmd.div_step) begin
            dcnt_ff <= dcnt_ff - wpdh_pkg::DIV_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sqrt_init) begin
         sx_ff <= d2_ff;
         sres_ff <= '0;
      end else if (cmd.sqrt_step) begin
         if (sx_ff >= strial) begin
            sx_ff <= sx_ff - strial;
            sres_ff <= (sres_ff >> 1) + sbit_ff;
         end else begin
            sres_ff <= sres_ff >> 1;
         end
      end
   end

   // histogram memory
   logic [VW-1:0] hist [NUM_BINS];
   logic [VW-1:0] hist_rd_ff;
   logic [KW-1:0] k_ff, k_in;
   logic [KW-1:0] acc_bin, hist_addr;
   logic [VW-1:0] amount;
   logic [VW:0] acc_sum;
   logic [VW-1:0] acc_sat;

   assign acc_bin = self_phase_ff ? '0
      : ((quot_ff > DV'(NUM_BINS - 1)) ? LAST_BIN : quot_ff[KW-1:0]);
   assign hist_addr = (cmd.acc_rd || cmd.acc_wr) ? acc_bin : k_ff;
   assign amount = self_phase_ff ? VW'(prod_ff) : VW'({prod_ff, 1'b0});
   assign acc_sum = {1'b0, hist_rd_ff} + {1'b0, amount};
   assign acc_sat = acc_sum[VW] ? {VW{1'b1}} : acc_sum[VW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.clr_step) begin
         hist[hist_addr] <= '0;
      end else if (cmd.acc_wr) begin
         hist[hist_addr] <= acc_sat;
      end
      if (cmd.acc_rd || cmd.out_rd) begin
         hist_rd_ff <= hist[hist_addr];
      end
   end

   always_comb begin
      k_in = k_ff;
      if (cmd.clr_init || cmd.out_init) begin
         k_in = '0;
      end else if (cmd.clr_step || cmd.out_next) begin
         k_in = k_ff + KW'(1);
      end
   end

   // result register
   logic rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0] rsp_data_ff;
   logic [wpdh_pkg::BIN_IDX_W-1:0] rsp_user_ff;
   logic rsp_last_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         k_ff <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= hist_rd_ff;
         rsp_user_ff <= wpdh_pkg::BIN_IDX_W'(k_ff);
         rsp_last_ff <= (k_ff == LAST_BIN);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;
   assign rsp_tlast = rsp_last_ff;

   always_comb begin
      status.self_mode = self_mode_ff;
      status.clr_last = (k_ff == LAST_BIN);
      status.pairs_none = self_mode_ff ? (count_a_ff < CW'(2))
         : (count_a_ff == '0 || count_b_ff == '0);
      status.pair_last = self_mode_ff ? (j_ext == cnt_a_m1 && i_ext == cnt_a_m2)
         : (j_ext == cnt_b_m1 && i_ext == cnt_a_m1);
      status.sqrt_done = (sbit_ff == '0);
      status.div_done = (dcnt_ff == '0);
      status.self_none = (count_a_ff == '0);
      status.self_last = (i_ext == cnt_a_m1);
      status.out_last = (k_ff == LAST_BIN);
      status.rsp_taken = rsp_valid_ff && rsp_tready;
   end

   a_count_a_bound: assert property (@(posedge clock) disable iff (reset)
      count_a_ff <= MAX_CNT)
      else $error("set A count past capacity");
   a_acc_monotone: assert property (@(posedge clock) disable iff (reset)
      cmd.acc_wr |-> acc_sat >= hist_rd_ff)
      else $error("bin accumulation decreased");
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> k_ff == LAST_BIN)
      else $error("last flag on a bin other than the final one");

endmodule

// ===== rtl/core/weighted_pair_distance_histogram.sv =====
// Top level of the weighted pair distance histogram: streaming ports, config port.
// Depends on wpdh_pkg, wpdh_ctrl and wpdh_datapath.
//
// Loads (command 0 or 1) are taken one per cycle. A compute (command 2) blocks
// input until all bins are delivered: the histogram is cleared, then each pair is
// processed (fetch, squares, 20-step square root, 20-step divide, read-modify-write
// of the bin), then in self mode the self term of each point is added, and then
// each bin in turn is read, loaded and held until rsp_tready takes it. The
// square root and divide units, one bit per cycle, set the pair rate.
module weighted_pair_distance_histogram #(
   parameter int MAX_POINTS = 1024,
   parameter int NUM_BINS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // x_pos[17:0], y_pos[35:18], z_pos[53:36], point_weight[69:54], zero pad
   input  logic [wpdh_pkg::REQ_DATA_W-1:0]     req_tdata,
   // command[1:0]
   input  logic [wpdh_pkg::CMD_W-1:0]          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // bin_value[47:0]
   output logic [wpdh_pkg::BIN_VAL_W-1:0]      rsp_tdata,
   // bin_index[5:0]
   output logic [wpdh_pkg::BIN_IDX_W-1:0]      rsp_tuser,
   // last_bin
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [wpdh_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [wpdh_pkg::BWIDTH_W-1:0]       csr_data
);

   wpdh_pkg::dp_cmd_type    cmd;
   wpdh_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   wpdh_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_command (req_tuser),
      .status      (status),
      .cmd         (cmd)
   );

   wpdh_datapath #(
      .MAX_POINTS (MAX_POINTS),
      .NUM_BINS   (NUM_BINS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .csr_write  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for weighted_pair_distance_histogram.
// Drives point loads and computes over the request stream and checks every reported bin
// against a behavioral histogram model kept here. Depends on wpdh_pkg and the RTL only.
`timescale 1ns / 100ps

module testbench;

   localparam int MAX_PTS = 1024;
   localparam int BINS = 64;
   localparam logic [wpdh_pkg::BIN_VAL_W-1:0] BIN_SAT = '1;
   localparam logic [wpdh_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct {
      logic [wpdh_pkg::CMD_W-1:0]          cmd;
      logic signed [wpdh_pkg::COORD_W-1:0] x;
      logic signed [wpdh_pkg::COORD_W-1:0] y;
      logic signed [wpdh_pkg::COORD_W-1:0] z;
      logic [wpdh_pkg::WEIGHT_W-1:0]       w;
   } point_item_type;

   typedef struct {
      logic [wpdh_pkg::BIN_IDX_W-1:0] idx;
      logic [wpdh_pkg::BIN_VAL_W-1:0] value;
      logic                           last;
   } bin_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [wpdh_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [wpdh_pkg::CMD_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [wpdh_pkg::BIN_VAL_W-1:0] rsp_tdata;
   logic [wpdh_pkg::BIN_IDX_W-1:0] rsp_tuser;
   logic rsp_tlast;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [wpdh_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [wpdh_pkg::BWIDTH_W-1:0] csr_data = '0;

   point_item_type pending_items[$];
   bin_report_type expected_bins[$];
   point_item_type set_a[MAX_PTS];
   point_item_type set_b[MAX_PTS];
   int unsigned count_a = 0;
   int unsigned count_b = 0;
   logic [wpdh_pkg::BWIDTH_W-1:0] cur_bin_width = wpdh_pkg::BIN_WIDTH_RESET;
   logic cur_self_mode = 1'b0;
   longint unsigned hist[BINS];

   int errors = 0;
   bit req_taken = 0;
   int req_gap = 0;
   int rsp_hold = 0;
   int stall_left = 0;
   bit pressure_done = 0;
   int rsp_count = 0;

   weighted_pair_distance_histogram u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic longint unsigned floor_root(longint unsigned d2);
      longint unsigned r, t;
      r = 0;
      for (int b = 20; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= d2) r = t;
      end
      return r;
   endfunction

   function automatic void bin_add(longint unsigned k, longint unsigned amount);
      longint unsigned s;
      s = hist[k] + amount;
      hist[k] = (s > BIN_SAT) ? BIN_SAT : s;
   endfunction

   function automatic void pair_add(point_item_type a, point_item_type b);
      longint dx, dy, dz;
      longint unsigned dist_val, wdt, k;
      dx = longint'(a.x) - longint'(b.x);
      dy = longint'(a.y) - longint'(b.y);
      dz = longint'(a.z) - longint'(b.z);
      dist_val = floor_root(longint'(dx * dx + dy * dy + dz * dz));
      wdt = (cur_bin_width == 0) ? 1 : cur_bin_width;
      k = dist_val / wdt;
      if (k > BINS - 1) k = BINS - 1;
      bin_add(k, 2 * longint'(a.w) * longint'(b.w));
   endfunction

   function automatic void histogram_predict(point_item_type it);
      bin_report_type r;
      case (it.cmd)
         wpdh_pkg::CMD_LOAD_A: if (count_a < MAX_PTS) begin
            set_a[count_a] = it;
            count_a++;
         end
         wpdh_pkg::CMD_LOAD_B: if (count_b < MAX_PTS) begin
            set_b[count_b] = it;
            count_b++;
         end
         wpdh_pkg::CMD_COMPUTE: begin
            for (int k = 0; k < BINS; k++) hist[k] = 0;
            if (cur_self_mode) begin
               for (int i = 0; i < count_a; i++)
                  for (int j = i + 1; j < count_a; j++) pair_add(set_a[i], set_a[j]);
               for (int i = 0; i < count_a; i++)
                  bin_add(0, longint'(set_a[i].w) * longint'(set_a[i].w));
            end else begin
               for (int i = 0; i < count_a; i++)
                  for (int j = 0; j < count_b; j++) pair_add(set_a[i], set_b[j]);
            end
            count_a = 0;
            count_b = 0;
            for (int k = 0; k < BINS; k++) begin
               r.idx = wpdh_pkg::BIN_IDX_W'(k);
               r.value = wpdh_pkg::BIN_VAL_W'(hist[k]);
               r.last = (k == BINS - 1);
               expected_bins.push_back(r);
            end
         end
         default: ;
      endcase
   endfunction

   // request driver
   always @(negedge clock) begin
      point_item_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            it = pending_items.pop_front();
            req_tdata <= {2'b00, it.w, it.z, it.y, it.x};
            req_tuser <= it.cmd;
            req_tvalid <= 1'b1;
            req_gap = pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response ready, with one long hold-off to back up the block
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!pressure_done && rsp_count >= 100) begin
         pressure_done = 1;
         stall_left = 600;
         rsp_tready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         rsp_hold = pick_gap();
      end
   end

   // monitor
   always @(posedge clock) begin
      point_item_type it;
      bin_report_type e;
      req_taken = !reset && req_tvalid && req_tready;
      if (req_taken) begin
         it.cmd = req_tuser;
         it.x = req_tdata[17:0];
         it.y = req_tdata[35:18];
         it.z = req_tdata[53:36];
         it.w = req_tdata[69:54];
         histogram_predict(it);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_count++;
         if (expected_bins.size() == 0) begin
            $error("unexpected bin transfer: index %0d value %0d", rsp_tuser, rsp_tdata);
            errors++;
         end else begin
            e = expected_bins.pop_front();
            if (rsp_tuser !== e.idx) begin
               $error("bin_index: expected %0d, got %0d", e.idx, rsp_tuser);
               errors++;
            end
            if (rsp_tdata !== e.value) begin
               $error("bin_value (bin %0d): expected %0d, got %0d", e.idx, e.value, rsp_tdata);
               errors++;
            end
            if (rsp_tlast !== e.last) begin
               $error("last_bin (bin %0d): expected %0d, got %0d", e.idx, e.last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   task automatic push_item(logic [wpdh_pkg::CMD_W-1:0] cmd, int x, int y, int z, int w);
      point_item_type it;
      it.cmd = cmd;
      it.x = wpdh_pkg::COORD_W'(x);
      it.y = wpdh_pkg::COORD_W'(y);
      it.z = wpdh_pkg::COORD_W'(z);
      it.w = wpdh_pkg::WEIGHT_W'(w);
      pending_items.push_back(it);
   endtask

   task automatic push_random_point(logic [wpdh_pkg::CMD_W-1:0] cmd, int bx, int by, int bz,
                                    bit near);
      if (near)
         push_item(cmd, bx + $urandom_range(0, 1023) - 512, by + $urandom_range(0, 1023) - 512,
                   bz + $urandom_range(0, 1023) - 512, $urandom_range(0, 65535));
      else
         push_item(cmd, $urandom, $urandom, $urandom, $urandom_range(0, 65535));
   endtask

   task automatic wait_drained();
      while (pending_items.size() > 0 || req_tvalid || expected_bins.size() > 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic csr_write(logic [wpdh_pkg::CSR_IDX_W-1:0] idx,
                            logic [wpdh_pkg::BWIDTH_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == wpdh_pkg::REG_BIN_WIDTH) cur_bin_width = value;
      else cur_self_mode = value[0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_phase(int n_items);
      int sent, na, nb, bx, by, bz;
      bit near;
      sent = 0;
      while (sent < n_items) begin
         na = $urandom_range(0, 7);
         nb = $urandom_range(0, 7);
         bx = $urandom_range(0, 200000) - 100000;
         by = $urandom_range(0, 200000) - 100000;
         bz = $urandom_range(0, 200000) - 100000;
         near = $urandom_range(0, 3) != 0;
         for (int i = 0; i < na + nb; i++) begin
            if (i < na) push_random_point(wpdh_pkg::CMD_LOAD_A, bx, by, bz, near);
            else push_random_point(wpdh_pkg::CMD_LOAD_B, bx, by, bz, near);
            if ($urandom_range(0, 15) == 0)
               push_item(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom);
         end
         push_item(wpdh_pkg::CMD_COMPUTE, $urandom, $urandom, $urandom, $urandom);
         sent += na + nb + 1;
      end
      wait_drained();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes, unused command, empty compute, fields ignored on compute
      push_item(wpdh_pkg::CMD_COMPUTE, $urandom, $urandom, $urandom, $urandom);
      push_item(wpdh_pkg::CMD_LOAD_A, -131072, -131072, -131072, 65535);
      push_item(wpdh_pkg::CMD_LOAD_A, 131071, 131071, 131071, 0);
      push_item(wpdh_pkg::CMD_LOAD_A, 0, 0, 0, 65535);
      push_item(wpdh_pkg::CMD_LOAD_B, 131071, 131071, 131071, 65535);
      push_item(wpdh_pkg::CMD_LOAD_B, 5, -3, 7, 1);
      push_item(wpdh_pkg::CMD_LOAD_B, -131072, 131071, 0, 32768);
      push_item(CMD_UNUSED, -1, -1, -1, 65535);
      push_item(wpdh_pkg::CMD_COMPUTE, -1, -1, -1, 65535);
      push_item(wpdh_pkg::CMD_LOAD_B, 1, 2, 3, 4);
      push_item(wpdh_pkg::CMD_COMPUTE, 0, 0, 0, 0);
      wait_drained();

      csr_write(wpdh_pkg::REG_SELF_MODE, 12'd1);
      push_item(wpdh_pkg::CMD_COMPUTE, 0, 0, 0, 0);
      push_item(wpdh_pkg::CMD_LOAD_A, 0, 0, 0, 65535);
      push_item(wpdh_pkg::CMD_LOAD_A, 16, 0, 0, 65535);
      push_item(wpdh_pkg::CMD_LOAD_A, -131072, 131071, -131072, 300);
      push_item(wpdh_pkg::CMD_LOAD_B, 9, 9, 9, 9);
      push_item(wpdh_pkg::CMD_COMPUTE, 0, 0, 0, 0);
      wait_drained();

      csr_write(wpdh_pkg::REG_BIN_WIDTH, 12'd1);
      csr_write(wpdh_pkg::REG_SELF_MODE, 12'd0);
      random_phase(35);
      csr_write(wpdh_pkg::REG_BIN_WIDTH, 12'd4095);
      csr_write(wpdh_pkg::REG_SELF_MODE, 12'd1);
      random_phase(35);
      csr_write(wpdh_pkg::REG_BIN_WIDTH, 12'd0);
      random_phase(30);
      csr_write(wpdh_pkg::REG_BIN_WIDTH, wpdh_pkg::BWIDTH_W'($urandom_range(1, 4095)));
      csr_write(wpdh_pkg::REG_SELF_MODE, 12'd0);
      random_phase(35);
      csr_write(wpdh_pkg::REG_BIN_WIDTH, wpdh_pkg::BWIDTH_W'($urandom_range(8, 400)));
      random_phase(30);
      csr_write(wpdh_pkg::REG_SELF_MODE, 12'd1);
      random_phase(30);

      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #100ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
